>>> rtl/core/msgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared widths, types, register codes and saturating fixed-point helpers
// for the momentum SGD parameter update block.
// ----------------------------------------------------------------------------
package msgd_pkg;

    // Value format: signed Q16.16
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 16;

    // Coefficient register widths (unsigned)
    localparam int L1_W       = 16;
    localparam int L2_W       = 17;
    localparam int MOM_W      = 17;
    localparam int GS_W       = 24;

    // Configuration port
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Product width: value and widest coefficient widths plus two bits
    localparam int PROD_W     = VALUE_W + GS_W + 2;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L1_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_KEEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SCALE = 2'd3;

    // Reset value of l2_keep: 1.0
    localparam logic [L2_W-1:0] L2_KEEP_RESET = L2_W'(1 << FRAC_W);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [L1_W-1:0]  l1_step;
        logic [L2_W-1:0]  l2_keep;
        logic [MOM_W-1:0] momentum;
        logic [GS_W-1:0]  grad_scale;
    } cfg_t;

    // Work entry handed from front to back
    typedef struct packed {
        value_t param_value;
        value_t velocity;
        value_t gradient;
        logic   is_bias;
    } work_t;

    // Saturating signed add
    function automatic value_t sat_add(input value_t a, input value_t b);
        logic signed [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        return s[VALUE_W-1:0];
    endfunction

    // Saturating signed subtract
    function automatic value_t sat_sub(input value_t a, input value_t b);
        logic signed [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        return s[VALUE_W-1:0];
    endfunction

    // Signed value times unsigned coefficient, full width
    function automatic prod_t mul_coef(input value_t v, input logic [GS_W-1:0] c);
        prod_t a;
        prod_t b;
        a = {{(PROD_W-VALUE_W){v[VALUE_W-1]}}, v};
        b = {{(PROD_W-GS_W){1'b0}}, c};
        return a * b;
    endfunction

    // Arithmetic shift by the fraction bits, then clamp to the value range
    function automatic value_t sat_frac(input prod_t p);
        prod_t                       sh;
        logic [PROD_W-VALUE_W:0]     hi;
        sh = p >>> FRAC_W;
        hi = sh[PROD_W-1:VALUE_W-1];
        if (!sh[PROD_W-1] && (|hi))
            return VALUE_MAX;
        if (sh[PROD_W-1] && !(&hi))
            return VALUE_MIN;
        return sh[VALUE_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/msgd_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgd_item_if / msgd_result_if
// Valid/ready channels for parameter items and update results.
// ----------------------------------------------------------------------------
interface msgd_item_if;
    logic             valid;
    logic             ready;
    msgd_pkg::value_t param_value;
    msgd_pkg::value_t velocity;
    msgd_pkg::value_t gradient;
    logic             is_bias;

    modport source (output valid, output param_value, output velocity,
                    output gradient, output is_bias, input ready);
    modport sink   (input valid, input param_value, input velocity,
                    input gradient, input is_bias, output ready);
endinterface

interface msgd_result_if;
    logic             valid;
    logic             ready;
    msgd_pkg::value_t new_param;
    msgd_pkg::value_t new_velocity;

    modport source (output valid, output new_param, output new_velocity, input ready);
    modport sink   (input valid, input new_param, input new_velocity, output ready);
endinterface
`default_nettype wire

>>> rtl/core/msgd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgd_front
// Accepts item transactions, classifies weight versus bias and applies the
// L1 sign step to the velocity before handing the entry to the queue.
// ----------------------------------------------------------------------------
module msgd_front (
    msgd_item_if.sink        item,
    input  wire msgd_pkg::cfg_t cfg,
    input  wire              queue_full,
    output logic             push,
    output msgd_pkg::work_t  entry
);

    msgd_pkg::value_t l1_ext;
    logic             param_pos;
    logic             param_neg;

    // Accept whenever the queue has room
    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    assign l1_ext    = {{(msgd_pkg::VALUE_W-msgd_pkg::L1_W){1'b0}}, cfg.l1_step};
    assign param_neg = item.param_value[msgd_pkg::VALUE_W-1];
    assign param_pos = !param_neg && (item.param_value != '0);

    // Move the velocity by l1_step against the weight's sign; biases and zero weights pass unchanged
    always_comb
    begin
        entry.param_value = item.param_value;
        entry.gradient    = item.gradient;
        entry.is_bias     = item.is_bias;
        if (item.is_bias)
            entry.velocity = item.velocity;
        else if (param_pos)
            entry.velocity = msgd_pkg::sat_sub(item.velocity, l1_ext);
        else if (param_neg)
            entry.velocity = msgd_pkg::sat_add(item.velocity, l1_ext);
        else
            entry.velocity = item.velocity;
    end

endmodule
`default_nettype wire

>>> rtl/core/msgd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgd_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module msgd_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire msgd_pkg::work_t push_data,
    input  wire              pop,
    output msgd_pkg::work_t  head,
    output logic             not_empty,
    output logic             full
);

    msgd_pkg::work_t                 mem_reg [msgd_pkg::QUEUE_DEPTH];
    logic [msgd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [msgd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [msgd_pkg::QPTR_W:0]       count_reg;
    logic [msgd_pkg::QPTR_W:0]       count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == (msgd_pkg::QPTR_W+1)'(msgd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (msgd_pkg::QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (msgd_pkg::QPTR_W+1)'(1);
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + msgd_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + msgd_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

>>> rtl/core/msgd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgd_back
// Five-stage arithmetic pipeline: L2 and gradient products, saturate,
// momentum product, gradient subtract, parameter add into the output
// register. The whole pipe advances when the output register can move.
// ----------------------------------------------------------------------------
module msgd_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire msgd_pkg::cfg_t cfg,
    input  wire msgd_pkg::work_t head,
    input  wire              head_valid,
    output logic             pop,
    msgd_result_if.source    result
);

    localparam int ZL2  = msgd_pkg::GS_W - msgd_pkg::L2_W;
    localparam int ZMOM = msgd_pkg::GS_W - msgd_pkg::MOM_W;

    logic advance;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    msgd_pkg::prod_t  s1_prod_l2_reg;
    msgd_pkg::prod_t  s1_prod_g_reg;
    msgd_pkg::value_t s1_vel_reg;
    msgd_pkg::value_t s1_param_reg;
    logic             s1_bias_reg;

    msgd_pkg::value_t s2_vel_reg;
    msgd_pkg::value_t s2_gterm_reg;
    msgd_pkg::value_t s2_param_reg;

    msgd_pkg::prod_t  s3_prod_m_reg;
    msgd_pkg::value_t s3_gterm_reg;
    msgd_pkg::value_t s3_param_reg;

    msgd_pkg::value_t s4_vel_reg;
    msgd_pkg::value_t s4_param_reg;

    msgd_pkg::value_t new_param_reg;
    msgd_pkg::value_t new_velocity_reg;

    // Move everything when the output slot is free or being taken
    assign advance = !out_valid_reg || result.ready;
    assign pop     = advance;

    assign result.valid        = out_valid_reg;
    assign result.new_param    = new_param_reg;
    assign result.new_velocity = new_velocity_reg;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Stage 1: L2 keep and gradient scale products
            s1_prod_l2_reg <= msgd_pkg::mul_coef(head.velocity, {{ZL2{1'b0}}, cfg.l2_keep});
            s1_prod_g_reg  <= msgd_pkg::mul_coef(head.gradient, cfg.grad_scale);
            s1_vel_reg     <= head.velocity;
            s1_param_reg   <= head.param_value;
            s1_bias_reg    <= head.is_bias;

            // Stage 2: rescale and clamp; biases skip the L2 factor
            s2_vel_reg   <= s1_bias_reg ? s1_vel_reg : msgd_pkg::sat_frac(s1_prod_l2_reg);
            s2_gterm_reg <= msgd_pkg::sat_frac(s1_prod_g_reg);
            s2_param_reg <= s1_param_reg;

            // Stage 3: momentum product
            s3_prod_m_reg <= msgd_pkg::mul_coef(s2_vel_reg, {{ZMOM{1'b0}}, cfg.momentum});
            s3_gterm_reg  <= s2_gterm_reg;
            s3_param_reg  <= s2_param_reg;

            // Stage 4: new velocity
            s4_vel_reg   <= msgd_pkg::sat_sub(msgd_pkg::sat_frac(s3_prod_m_reg), s3_gterm_reg);
            s4_param_reg <= s3_param_reg;

            // Output: new parameter
            new_velocity_reg <= s4_vel_reg;
            new_param_reg    <= msgd_pkg::sat_add(s4_param_reg, s4_vel_reg);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/momentum_sgd_param_update.sv
`default_nettype none
// An accepted item is written to the queue, then passes stages 1 to 4
// and the output register before its result is valid.
// Throughput: one item per cycle; the front stalls only when the 4-entry
// queue is full, the back only when the result is not taken.
// Reset clears the queue and stage valid bits; l2_keep resets to 1.0,
// l1_step, momentum and grad_scale to 0.
// ----------------------------------------------------------------------------
// momentum_sgd_param_update
// SGD-with-momentum step with L1/L2 decay on signed Q16.16 values: holds
// the coefficient registers and joins front, queue and back pipeline.
// ----------------------------------------------------------------------------
module momentum_sgd_param_update (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [msgd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [msgd_pkg::CFG_DATA_W-1:0]     cfg_data,
    msgd_item_if.sink                          item,
    msgd_result_if.source                      result
);

    msgd_pkg::cfg_t  cfg_reg;
    msgd_pkg::work_t front_entry;
    msgd_pkg::work_t queue_head;
    logic            front_push;
    logic            queue_full;
    logic            queue_valid;
    logic            back_pop;

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.l1_step    <= '0;
            cfg_reg.l2_keep    <= msgd_pkg::L2_KEEP_RESET;
            cfg_reg.momentum   <= '0;
            cfg_reg.grad_scale <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msgd_pkg::CFG_L1_STEP:
                    cfg_reg.l1_step <= cfg_data[msgd_pkg::L1_W-1:0];
                msgd_pkg::CFG_L2_KEEP:
                    cfg_reg.l2_keep <= cfg_data[msgd_pkg::L2_W-1:0];
                msgd_pkg::CFG_MOMENTUM:
                    cfg_reg.momentum <= cfg_data[msgd_pkg::MOM_W-1:0];
                msgd_pkg::CFG_GRAD_SCALE:
                    cfg_reg.grad_scale <= cfg_data[msgd_pkg::GS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    msgd_front u_front (
        .item       (item),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (front_push),
        .entry      (front_entry)
    );

    msgd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_entry),
        .pop       (back_pop),
        .head      (queue_head),
        .not_empty (queue_valid),
        .full      (queue_full)
    );

    msgd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (queue_head),
        .head_valid (queue_valid),
        .pop        (back_pop),
        .result     (result)
    );

endmodule
`default_nettype wire
